### design/htfd_pkg.sv
// Shared types, constants and the CRC-8 step for the frame decoder.
package htfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 3;
    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;
    localparam int TPROD_W = 31;
    localparam int HPROD_W = 30;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    localparam logic [TEMP_W-1:0] T_SCALE  = 15'd17500;
    localparam logic [HUM_W-1:0]  H_SCALE  = 14'd10000;
    localparam logic [WORD_W-1:0] DIV_K    = 16'hFFFF;
    localparam logic signed [TEMP_W:0] T_OFFSET = 16'sd4500;

    typedef struct packed {
        logic               failed;
        logic [TPROD_W-1:0] t_prod;
        logic [HPROD_W-1:0] h_prod;
    } prod_t;

    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### design/htfd_in_if.sv
// Byte input channel.
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

### design/htfd_out_if.sv
// Decoded frame result channel.
interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    modport source (output valid, output status, output temperature_centi,
                    output humidity_centi, input ready);
    modport sink   (input valid, input status, input temperature_centi,
                    input humidity_centi, output ready);
endinterface

### design/htfd_parser.sv
// Input register, frame position/CRC tracking and scale products.
module htfd_parser (
    input  logic            clk,
    input  logic            rst_n,
    htfd_in_if.sink         rx,
    output logic            prod_valid,
    output htfd_pkg::prod_t prod,
    input  logic            prod_take
);
    import htfd_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_start_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [WORD_W-1:0] temp_reg, temp_next;
    logic [WORD_W-1:0] hum_reg, hum_next;
    logic              tcf_reg, tcf_next;

    logic              p_valid_reg, p_valid_next;
    prod_t             p_reg, p_next;

    logic [POS_W-1:0]  pos;
    logic              is_last;
    logic              fire;
    logic              s2_free;
    logic              load;

    always_comb
    begin
        pos = (s1_start_reg || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
        is_last = (pos == POS_H_CRC);
        s2_free = !p_valid_reg || prod_take;
        fire = s1_valid_reg && (!is_last || s2_free);
        load = rx.valid && rx.ready;

        temp_next = temp_reg;
        hum_next  = hum_reg;
        crc_next  = crc_reg;
        tcf_next  = tcf_reg;
        case (pos)
            POS_T_HI:
            begin
                temp_next = {s1_byte_reg, 8'h00};
                crc_next  = crc8_update(CRC_INIT, s1_byte_reg);
            end
            POS_T_LO:
            begin
                temp_next = {temp_reg[WORD_W-1:BYTE_W], s1_byte_reg};
                crc_next  = crc8_update(crc_reg, s1_byte_reg);
            end
            POS_T_CRC:
                tcf_next = (crc_reg != s1_byte_reg);
            POS_H_HI:
            begin
                hum_next = {s1_byte_reg, 8'h00};
                crc_next = crc8_update(CRC_INIT, s1_byte_reg);
            end
            POS_H_LO:
            begin
                hum_next = {hum_reg[WORD_W-1:BYTE_W], s1_byte_reg};
                crc_next = crc8_update(crc_reg, s1_byte_reg);
            end
            default: ;
        endcase
        pos_next = is_last ? POS_T_HI : pos + 3'd1;

        // failed frame: zero products give -4500 and 0 downstream
        p_next.failed = tcf_reg || (crc_reg != s1_byte_reg);
        p_next.t_prod = p_next.failed ? '0 : TPROD_W'(T_SCALE) * TPROD_W'(temp_reg);
        p_next.h_prod = p_next.failed ? '0 : HPROD_W'(H_SCALE) * HPROD_W'(hum_reg);

        if (fire && is_last)
            p_valid_next = 1'b1;
        else if (prod_take)
            p_valid_next = 1'b0;
        else
            p_valid_next = p_valid_reg;

        if (load)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign rx.ready   = !s1_valid_reg || fire;
    assign prod_valid = p_valid_reg;
    assign prod       = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            pos_reg      <= POS_T_HI;
            crc_reg      <= CRC_INIT;
            temp_reg     <= '0;
            hum_reg      <= '0;
            tcf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            p_valid_reg  <= p_valid_next;
            if (fire)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                temp_reg <= temp_next;
                hum_reg  <= hum_next;
                tcf_reg  <= tcf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_byte_reg  <= rx.rx_byte;
            s1_start_reg <= rx.frame_start;
        end
        if (fire && is_last)
            p_reg <= p_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_H_CRC)
        else $error("frame position out of range");

    a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !prod_take |=> p_valid_reg && $stable(p_reg))
        else $error("pending product lost or changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && p_reg.failed |-> p_reg.t_prod == '0 && p_reg.h_prod == '0)
        else $error("failed frame carries nonzero products");

endmodule

### design/htfd_scaler.sv
// Divide-by-65535 correction, temperature offset and result register.
module htfd_scaler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            prod_valid,
    input  htfd_pkg::prod_t prod,
    output logic            prod_take,
    htfd_out_if.source      result
);
    import htfd_pkg::*;

    logic                     valid_reg, valid_next;
    logic                     status_reg;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [HUM_W-1:0]         hum_reg, hum_next;

    logic [TEMP_W-1:0] tq0;
    logic [HUM_W-1:0]  hq0;
    logic [WORD_W:0]   tr0, hr0;
    logic [TEMP_W-1:0] tq;
    logic [HUM_W-1:0]  hq;
    logic signed [TEMP_W:0] tc;

    // x / 65535: q0 = x >> 16, remainder q0 + x[15:0] < 2*65535, one fixup
    always_comb
    begin
        tq0 = prod.t_prod[TPROD_W-1:WORD_W];
        hq0 = prod.h_prod[HPROD_W-1:WORD_W];
        tr0 = {1'b0, prod.t_prod[WORD_W-1:0]} + (WORD_W+1)'(tq0);
        hr0 = {1'b0, prod.h_prod[WORD_W-1:0]} + (WORD_W+1)'(hq0);
        tq  = tq0 + TEMP_W'(tr0 >= {1'b0, DIV_K});
        hq  = hq0 + HUM_W'(hr0 >= {1'b0, DIV_K});
        tc  = $signed({1'b0, tq}) - T_OFFSET;
        temp_next = tc[TEMP_W-1:0];
        hum_next  = hq;

        prod_take = prod_valid && (!valid_reg || result.ready);
        if (prod_take)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign result.valid             = valid_reg;
    assign result.status            = status_reg;
    assign result.temperature_centi = temp_reg;
    assign result.humidity_centi    = hum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (prod_take)
        begin
            status_reg <= prod.failed;
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
        end
    end

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hum_reg <= H_SCALE)
        else $error("humidity beyond full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> temp_reg >= -15'sd4500 && temp_reg <= 15'sd13000)
        else $error("temperature out of range");

    a_fail_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg |-> temp_reg == -15'sd4500 && hum_reg == '0)
        else $error("failed frame not reported at sensor defaults");

endmodule

### design/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature sensor frame decoder.
//
//   channel  dir  beat payload
//   rx       in   rx_byte[7:0], frame_start
//   result   out  status, temperature_centi[14:0] (signed), humidity_centi[13:0]
//
// One byte per cycle sustained while results are taken; bytes without a result never stall.
// After the sixth byte's beat the result passes the input register, the product register
// (CRC check and scale multiply), then the divide fixup into the output register.
// Reset clears the frame position to the first byte and the CRC to 0xFF.
// A stalled result holds in the output register; one more result waits behind it
// before rx drops ready, and only while the sixth byte of a frame is next.
module humidity_temp_frame_decoder (
    input  logic       clk,
    input  logic       rst_n,
    htfd_in_if.sink    rx,
    htfd_out_if.source result
);
    import htfd_pkg::*;

    logic  prod_valid;
    logic  prod_take;
    prod_t prod;

    htfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_take  (prod_take)
    );

    htfd_scaler u_scaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_take  (prod_take),
        .result     (result)
    );

endmodule

### bench/humidity_temp_frame_decoder_test.sv
// Self-checking bench for the sensor frame decoder: CRC checks and scaled readings.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_test;

    import htfd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BYTES = 1800;

    typedef struct {
        logic                     status;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]         humidity_centi;
    } reading_t;

    logic clk;
    logic rst_n;

    htfd_in_if  rx_ch ();
    htfd_out_if res_ch ();

    humidity_temp_frame_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // decoder shadow state
    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] crc_acc;
    logic [WORD_W-1:0] temp_shadow;
    logic [WORD_W-1:0] hum_raw;
    logic              temp_crc_bad;

    reading_t pending_readings[$];

    int  error_count;
    int  bytes_sent;
    int  burst_left;
    bit  no_gaps;
    bit  hold_req;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout at %0t after %0d cycles", $time, cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] sensor_crc8(input logic [BYTE_W-1:0] b0,
                                                      input logic [BYTE_W-1:0] b1);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = CRC_INIT;
        for (int k = 0; k < 2; k++)
        begin
            c = c ^ ((k == 0) ? b0 : b1);
            for (int i = 0; i < BYTE_W; i++)
            begin
                fb = c[BYTE_W-1];
                c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] c_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = c_in ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb = c[BYTE_W-1];
            c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic fs);
        logic [POS_W-1:0] p;
        reading_t         r;
        int unsigned      t_scaled;
        int unsigned      h_scaled;
        p = (fs || frame_pos > POS_H_CRC) ? POS_T_HI : frame_pos;
        case (p)
            POS_T_HI:
            begin
                temp_shadow = {b, 8'h00};
                crc_acc     = crc_step(CRC_INIT, b);
            end
            POS_T_LO:
            begin
                temp_shadow[7:0] = b;
                crc_acc          = crc_step(crc_acc, b);
            end
            POS_T_CRC: temp_crc_bad = (crc_acc != b);
            POS_H_HI:
            begin
                hum_raw = {b, 8'h00};
                crc_acc = crc_step(CRC_INIT, b);
            end
            POS_H_LO:
            begin
                hum_raw[7:0] = b;
                crc_acc      = crc_step(crc_acc, b);
            end
            default: ;
        endcase
        if (p != POS_H_CRC)
        begin
            frame_pos = p + 1'b1;
            return;
        end
        frame_pos = POS_T_HI;
        r.status  = temp_crc_bad || (crc_acc != b);
        if (r.status)
        begin
            r.temperature_centi = -15'sd4500;
            r.humidity_centi    = '0;
        end
        else
        begin
            t_scaled = (32'd17500 * temp_shadow) / 32'd65535;
            h_scaled = (32'd10000 * hum_raw) / 32'd65535;
            r.temperature_centi = TEMP_W'(int'(t_scaled) - 4500);
            r.humidity_centi    = HUM_W'(h_scaled);
        end
        pending_readings.push_back(r);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= fs;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        decode_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] hw,
                              input bit t_bad, input bit h_bad, input logic fs);
        logic [BYTE_W-1:0] tc;
        logic [BYTE_W-1:0] hc;
        tc = sensor_crc8(tw[15:8], tw[7:0]);
        hc = sensor_crc8(hw[15:8], hw[7:0]);
        if (t_bad)
            tc = tc ^ BYTE_W'($urandom_range(1, 255));
        if (h_bad)
            hc = hc ^ BYTE_W'($urandom_range(1, 255));
        send_byte(tw[15:8], fs);
        send_byte(tw[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(hw[15:8], 1'b0);
        send_byte(hw[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return WORD_W'($urandom_range(0, 15));
            3: return WORD_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_readings.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_scale_extremes();
        send_frame(16'h0000, 16'hFFFF, 0, 0, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 0, 0, 1'b1);
    endtask

    // no frame_start: position wraps after the sixth byte
    task automatic test_wrap_without_start();
        send_frame(16'h8000, 16'h7FFF, 0, 0, 1'b0);
    endtask

    task automatic test_checksum_mismatch();
        send_frame(16'h6666, 16'h8000, 1, 0, 1'b1);
    endtask

    // partial frame dropped, then a frame with a bad humidity CRC
    task automatic test_restart_mid_frame();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_frame(16'h1234, 16'hBEEF, 0, 1, 1'b1);
    endtask

    task automatic test_output_backpressure();
        no_gaps  = 1;
        hold_req = 1;
        for (int i = 0; i < 8; i++)
            send_frame(pick_word(), pick_word(), 0, 0, 1'b1);
        no_gaps = 0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int start_count;
        int kind;
        int n;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                no_gaps = ~no_gaps;
                burst_left = 0;
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
            end
            else if (kind == 1)
            begin
                // truncated frame
                n = $urandom_range(1, 5);
                send_byte(BYTE_W'($urandom), 1'b1);
                repeat (n - 1)
                    send_byte(BYTE_W'($urandom), 1'b0);
            end
            else
            begin
                send_frame(pick_word(), pick_word(), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 7) == 0, $urandom_range(0, 4) != 0);
            end
        end
        no_gaps = 0;
    endtask

    // result sink: randomly picked stall patterns; long hold on request
    initial
    begin
        int sink_mode;
        int mode_cycles;
        int hold_count;
        sink_mode   = 0;
        mode_cycles = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                hold_req = 0;
            end
            else
            begin
                mode_cycles++;
                if (mode_cycles == 64)
                begin
                    mode_cycles = 0;
                    sink_mode = $urandom_range(0, 3);
                end
                case (sink_mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= (mode_cycles % 5) > 1;
                    default: res_ch.ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with no reading pending", $time);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (res_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, res_ch.status);
                end
                if (res_ch.temperature_centi !== want.temperature_centi)
                begin
                    error_count++;
                    $display("%0t: temperature_centi expected %0d got %0d", $time,
                             want.temperature_centi, res_ch.temperature_centi);
                end
                if (res_ch.humidity_centi !== want.humidity_centi)
                begin
                    error_count++;
                    $display("%0t: humidity_centi expected %0d got %0d", $time,
                             want.humidity_centi, res_ch.humidity_centi);
                end
            end
        end
    end

    initial
    begin
        error_count  = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        no_gaps      = 0;
        hold_req     = 0;
        frame_pos    = POS_T_HI;
        crc_acc      = CRC_INIT;
        temp_shadow  = '0;
        hum_raw      = '0;
        temp_crc_bad = 1'b0;
        rst_n             <= 1'b0;
        rx_ch.valid       <= 1'b0;
        rx_ch.rx_byte     <= '0;
        rx_ch.frame_start <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scale_extremes();
        test_wrap_without_start();
        test_checksum_mismatch();
        test_restart_mid_frame();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
